>>> sv/cckb_pkg.sv
// Shared types and constants for the clipped color-key sprite blitter.
// No dependencies; the files that use it refer to this package by scoped names.
`default_nettype none

package cckb_pkg;

   localparam int ADDR_BITS = 24;
   localparam int DIM_BITS  = 12;
   localparam int CSR_ADDR_BITS = 4;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [DIM_BITS-1:0]  dim_type;

   localparam dim_type    MAX_DIM   = 12'd2048;
   localparam logic [6:0] PCT_FULL  = 7'd100;
   localparam logic [7:0] TINT_BYTE2 = 8'd50;

   // floor(p / 100) == (p * RECIP_100) >> RECIP_SHIFT for p < 2^18
   localparam logic [18:0] RECIP_100   = 19'd335545;
   localparam int          RECIP_SHIFT = 25;

   // request operation codes
   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   // draw modes
   localparam logic [1:0] MODE_KEYED  = 2'd0;
   localparam logic [1:0] MODE_TINT   = 2'd1;
   localparam logic [1:0] MODE_OPAQUE = 2'd2;

   // byte enables
   localparam logic [3:0] MASK_FULL = 4'hf;
   localparam logic [3:0] MASK_TINT = 4'h7;
   localparam logic [3:0] MASK_NONE = 4'h0;

   // register indexes (word address)
   localparam logic [1:0] REG_TRANS_KEY     = 2'd0;
   localparam logic [1:0] REG_TARGET_WIDTH  = 2'd1;
   localparam logic [1:0] REG_TARGET_HEIGHT = 2'd2;
   localparam logic [1:0] REG_TARGET_PITCH  = 2'd3;

   localparam logic [23:0] TRANS_KEY_RST     = 24'd0;
   localparam dim_type     TARGET_WIDTH_RST  = 12'd640;
   localparam dim_type     TARGET_HEIGHT_RST = 12'd480;
   localparam logic [13:0] TARGET_PITCH_RST  = 14'd2560;

   localparam int QDEPTH    = 2;
   localparam int QPTR_BITS = 1;
   localparam int QCNT_BITS = 2;

   typedef struct packed {
      logic [23:0] trans_key;
      dim_type     target_width;
      dim_type     target_height;
      logic [13:0] target_pitch;
   } cfg_type;

   // one in-window pixel travelling from front to back
   typedef struct packed {
      addr_type    dest_address;
      logic [31:0] pixel;
      logic [1:0]  mode;
      logic        last;
   } q_entry_type;

   typedef struct packed {
      logic push;
      logic full;
   } q_ctrl_type;

   typedef enum logic [1:0] {
      FE_READY,
      FE_PROD,
      FE_DIV,
      FE_WIN
   } fe_state_type;

endpackage

`default_nettype wire

>>> sv/cckb_if.sv
// Request and response channel interfaces of the sprite blitter.
// Depends on nothing; field widths follow the block's item layout.
`default_nettype none

interface cckb_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic signed [12:0] start_x;
   logic signed [12:0] start_y;
   logic [6:0]         width_percent;
   logic [1:0]         draw_mode;
   logic [11:0]        sprite_cols;
   logic [11:0]        sprite_rows;
   logic [10:0]        centre_x;
   logic [10:0]        centre_y;
   logic [31:0]        pixel;

   modport source (
      output valid, operation, start_x, start_y, width_percent, draw_mode,
             sprite_cols, sprite_rows, centre_x, centre_y, pixel,
      input  ready
   );
   modport sink (
      input  valid, operation, start_x, start_y, width_percent, draw_mode,
             sprite_cols, sprite_rows, centre_x, centre_y, pixel,
      output ready
   );
endinterface

interface cckb_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] dest_address;
   logic [31:0] write_data;
   logic [3:0]  byte_mask;
   logic        last;

   modport source (
      output valid, dest_address, write_data, byte_mask, last,
      input  ready
   );
   modport sink (
      input  valid, dest_address, write_data, byte_mask, last,
      output ready
   );
endinterface

`default_nettype wire

>>> sv/cckb_csr.sv
// APB-style configuration registers: color key and target surface geometry.
// Depends on cckb_pkg.
`default_nettype none

module cckb_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [cckb_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]                        pwdata,
   output logic [31:0]                             prdata,
   output logic                                    pready,
   output cckb_pkg::cfg_type                       cfg
);

   cckb_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            cckb_pkg::REG_TRANS_KEY:     cfg_in.trans_key     = pwdata[23:0];
            cckb_pkg::REG_TARGET_WIDTH:  cfg_in.target_width  = pwdata[11:0];
            cckb_pkg::REG_TARGET_HEIGHT: cfg_in.target_height = pwdata[11:0];
            cckb_pkg::REG_TARGET_PITCH:  cfg_in.target_pitch  = pwdata[13:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trans_key     <= cckb_pkg::TRANS_KEY_RST;
         cfg_ff.target_width  <= cckb_pkg::TARGET_WIDTH_RST;
         cfg_ff.target_height <= cckb_pkg::TARGET_HEIGHT_RST;
         cfg_ff.target_pitch  <= cckb_pkg::TARGET_PITCH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         cckb_pkg::REG_TRANS_KEY:     prdata = {8'd0, cfg_ff.trans_key};
         cckb_pkg::REG_TARGET_WIDTH:  prdata = {20'd0, cfg_ff.target_width};
         cckb_pkg::REG_TARGET_HEIGHT: prdata = {20'd0, cfg_ff.target_height};
         cckb_pkg::REG_TARGET_PITCH:  prdata = {18'd0, cfg_ff.target_pitch};
         default:                     prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> sv/cckb_queue.sv
// Small FIFO between the front (window walk) and back (pixel ops) stages.
// Depends on cckb_pkg.
`default_nettype none

module cckb_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cckb_pkg::q_ctrl_type    ctrl_in,
   output logic                         full,
   input  wire cckb_pkg::q_entry_type   push_data,
   input  wire logic                    pop,
   output logic                         empty,
   output cckb_pkg::q_entry_type        pop_data
);

   cckb_pkg::q_entry_type                 entries_ff [cckb_pkg::QDEPTH];
   logic [cckb_pkg::QPTR_BITS-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [cckb_pkg::QPTR_BITS-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [cckb_pkg::QCNT_BITS-1:0]        count_ff, count_in;
   logic                                  do_push, do_pop;

   assign full     = (count_ff == cckb_pkg::QCNT_BITS'(cckb_pkg::QDEPTH));
   assign empty    = (count_ff == '0);
   // ctrl_in.full is the front's copy of full
   assign do_push  = ctrl_in.push && !ctrl_in.full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> sv/cckb_front.sv
// Front stage: accepts requests, sets up the clipped window on a begin request
// and walks the sprite raster, queueing in-window pixels. Depends on cckb_pkg, cckb_if.
`default_nettype none

module cckb_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cckb_pkg::cfg_type       cfg,
   cckb_req_if.sink                     req,
   output cckb_pkg::q_ctrl_type         q_ctrl,
   input  wire logic                    q_full,
   output cckb_pkg::q_entry_type        q_data
);

   cckb_pkg::fe_state_type state_ff, state_in;

   // setup registers
   logic [1:0]          bmode_ff, bmode_in;
   logic [6:0]          pct_ff, pct_in;
   logic [11:0]         cols_ff, cols_in;
   logic [11:0]         rows_ff, rows_in;
   logic signed [13:0]  x_ff, x_in;
   logic signed [13:0]  y_ff, y_in;
   logic [17:0]         prod_ff, prod_in;
   logic [11:0]         left_ff, left_in;
   logic [11:0]         top_ff, top_in;
   logic signed [13:0]  bottom_ff, bottom_in;
   logic [11:0]         sw_ff, sw_in;
   logic [25:0]         rowmul_ff, rowmul_in;

   // draw state
   logic                active_ff, active_in;
   logic [1:0]          mode_ff, mode_in;
   logic [11:0]         full_cols_ff, full_cols_in;
   logic [11:0]         col0_ff, col0_in;
   logic [11:0]         row0_ff, row0_in;
   logic [11:0]         wcols_ff, wcols_in;
   logic [11:0]         wrows_ff, wrows_in;
   logic [11:0]         col_cnt_ff, col_cnt_in;
   logic [11:0]         row_cnt_ff, row_cnt_in;
   cckb_pkg::addr_type  waddr_ff, waddr_in;
   cckb_pkg::addr_type  raddr_ff, raddr_in;

   logic                req_ready;
   logic                req_fire;
   logic                begin_fire;
   logic                pixel_fire;

   // begin request decode
   logic [6:0]          pct_sat;
   logic [11:0]         cols_clamp;
   logic [11:0]         rows_clamp;
   logic [10:0]         cx_sel;
   logic [10:0]         cy_sel;

   // setup arithmetic
   logic [18:0]         prod_full;
   logic [36:0]         recip_full;
   logic signed [13:0]  bot_sum;
   logic signed [13:0]  th_s;
   logic signed [13:0]  tw_s;
   logic signed [13:0]  right_sum;
   logic signed [13:0]  right_s;
   logic signed [13:0]  left_s;
   logic signed [13:0]  top_s;
   logic signed [13:0]  col0_d;
   logic signed [13:0]  row0_d;
   logic signed [13:0]  wcols_d;
   logic signed [13:0]  wrows_d;
   logic                win_empty;
   cckb_pkg::addr_type  first_addr;

   // raster walk
   logic [11:0]         col_off;
   logic [11:0]         row_off;
   logic [12:0]         col_next;
   logic                in_window;
   logic                row_end;
   logic                last_px;
   cckb_pkg::addr_type  raddr_step;

   assign req_fire   = req.valid && req_ready;
   assign begin_fire = req_fire && (req.operation == cckb_pkg::OP_BEGIN);
   assign pixel_fire = req_fire && (req.operation == cckb_pkg::OP_PIXEL) && active_ff;

   assign pct_sat    = (req.width_percent > cckb_pkg::PCT_FULL) ?
                       cckb_pkg::PCT_FULL : req.width_percent;
   assign cols_clamp = (req.sprite_cols > cckb_pkg::MAX_DIM) ?
                       cckb_pkg::MAX_DIM : req.sprite_cols;
   assign rows_clamp = (req.sprite_rows > cckb_pkg::MAX_DIM) ?
                       cckb_pkg::MAX_DIM : req.sprite_rows;
   assign cx_sel = (req.draw_mode == cckb_pkg::MODE_OPAQUE) ? 11'd0 : req.centre_x;
   assign cy_sel = (req.draw_mode == cckb_pkg::MODE_OPAQUE) ? 11'd0 : req.centre_y;

   assign prod_full  = {7'd0, cols_ff} * {12'd0, pct_ff};
   assign recip_full = {19'd0, prod_ff} * {18'd0, cckb_pkg::RECIP_100};

   assign th_s    = $signed({2'b00, cfg.target_height});
   assign tw_s    = $signed({2'b00, cfg.target_width});
   assign bot_sum = y_ff + $signed({2'b00, rows_ff});

   assign left_s    = $signed({2'b00, left_ff});
   assign top_s     = $signed({2'b00, top_ff});
   assign right_sum = x_ff + $signed({2'b00, sw_ff});
   assign right_s   = (right_sum > tw_s) ? tw_s : right_sum;
   assign win_empty = (right_s <= left_s) || (bottom_ff <= top_s);
   assign col0_d    = left_s - x_ff;
   assign row0_d    = top_s - y_ff;
   assign wcols_d   = right_s - left_s;
   assign wrows_d   = bottom_ff - top_s;
   assign first_addr = cckb_pkg::addr_type'(rowmul_ff) +
                       cckb_pkg::addr_type'({left_ff, 2'b00});

   // pixel classification against the current window
   assign col_off   = col_cnt_ff - col0_ff;
   assign row_off   = row_cnt_ff - row0_ff;
   assign in_window = (row_cnt_ff >= row0_ff) && (row_off < wrows_ff) &&
                      (col_cnt_ff >= col0_ff) && (col_off < wcols_ff);
   assign col_next = {1'b0, col_cnt_ff} + 13'd1;
   assign row_end  = (col_off == wcols_ff - 12'd1);
   assign last_px  = row_end && (row_off == wrows_ff - 12'd1);
   assign raddr_step = raddr_ff + cckb_pkg::addr_type'(cfg.target_pitch);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cckb_pkg::FE_READY: if (begin_fire) state_in = cckb_pkg::FE_PROD;
         cckb_pkg::FE_PROD:  state_in = cckb_pkg::FE_DIV;
         cckb_pkg::FE_DIV:   state_in = cckb_pkg::FE_WIN;
         cckb_pkg::FE_WIN:   state_in = cckb_pkg::FE_READY;
         default:            state_in = cckb_pkg::FE_READY;
      endcase
   end

   // state outputs
   always_comb begin
      unique case (state_ff)
         cckb_pkg::FE_READY: req_ready = !q_full;
         default:            req_ready = 1'b0;
      endcase
   end

   assign req.ready = req_ready;

   // datapath
   always_comb begin
      bmode_in     = bmode_ff;
      pct_in       = pct_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      prod_in      = prod_ff;
      left_in      = left_ff;
      top_in       = top_ff;
      bottom_in    = bottom_ff;
      sw_in        = sw_ff;
      rowmul_in    = rowmul_ff;
      active_in    = active_ff;
      mode_in      = mode_ff;
      full_cols_in = full_cols_ff;
      col0_in      = col0_ff;
      row0_in      = row0_ff;
      wcols_in     = wcols_ff;
      wrows_in     = wrows_ff;
      col_cnt_in   = col_cnt_ff;
      row_cnt_in   = row_cnt_ff;
      waddr_in     = waddr_ff;
      raddr_in     = raddr_ff;

      unique case (state_ff)
         cckb_pkg::FE_READY: begin
            if (begin_fire) begin
               // a new begin drops any draw in progress
               active_in = 1'b0;
               bmode_in  = req.draw_mode;
               pct_in    = pct_sat;
               cols_in   = cols_clamp;
               rows_in   = rows_clamp;
               x_in      = $signed({req.start_x[12], req.start_x}) -
                           $signed({3'b000, cx_sel});
               y_in      = $signed({req.start_y[12], req.start_y}) -
                           $signed({3'b000, cy_sel});
            end else if (pixel_fire) begin
               if (col_next >= {1'b0, full_cols_ff}) begin
                  col_cnt_in = 12'd0;
                  row_cnt_in = row_cnt_ff + 12'd1;
               end else begin
                  col_cnt_in = col_next[11:0];
               end
               if (in_window) begin
                  if (row_end) begin
                     raddr_in = raddr_step;
                     waddr_in = raddr_step;
                  end else begin
                     waddr_in = waddr_ff + cckb_pkg::addr_type'(4);
                  end
                  if (last_px) active_in = 1'b0;
               end
            end
         end
         cckb_pkg::FE_PROD: begin
            prod_in   = prod_full[17:0];
            left_in   = x_ff[13] ? 12'd0 : x_ff[11:0];
            top_in    = y_ff[13] ? 12'd0 : y_ff[11:0];
            bottom_in = (bot_sum > th_s) ? th_s : bot_sum;
         end
         cckb_pkg::FE_DIV: begin
            sw_in     = recip_full[36:25];
            rowmul_in = {14'd0, top_ff} * {12'd0, cfg.target_pitch};
         end
         cckb_pkg::FE_WIN: begin
            if (!win_empty) begin
               active_in    = 1'b1;
               mode_in      = bmode_ff;
               full_cols_in = cols_ff;
               col0_in      = col0_d[11:0];
               row0_in      = row0_d[11:0];
               wcols_in     = wcols_d[11:0];
               wrows_in     = wrows_d[11:0];
               col_cnt_in   = 12'd0;
               row_cnt_in   = 12'd0;
               raddr_in     = first_addr;
               waddr_in     = first_addr;
            end
         end
         default: begin
            active_in = active_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cckb_pkg::FE_READY;
         active_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      bmode_ff     <= bmode_in;
      pct_ff       <= pct_in;
      cols_ff      <= cols_in;
      rows_ff      <= rows_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      prod_ff      <= prod_in;
      left_ff      <= left_in;
      top_ff       <= top_in;
      bottom_ff    <= bottom_in;
      sw_ff        <= sw_in;
      rowmul_ff    <= rowmul_in;
      mode_ff      <= mode_in;
      full_cols_ff <= full_cols_in;
      col0_ff      <= col0_in;
      row0_ff      <= row0_in;
      wcols_ff     <= wcols_in;
      wrows_ff     <= wrows_in;
      col_cnt_ff   <= col_cnt_in;
      row_cnt_ff   <= row_cnt_in;
      waddr_ff     <= waddr_in;
      raddr_ff     <= raddr_in;
   end

   assign q_ctrl.push = pixel_fire && in_window;
   assign q_ctrl.full = q_full;

   assign q_data.dest_address = waddr_ff;
   assign q_data.pixel        = req.pixel;
   assign q_data.mode         = mode_ff;
   assign q_data.last         = last_px;

endmodule

`default_nettype wire

>>> sv/cckb_back.sv
// Back stage: color-key test, tint and byte enables, then the response register.
// Depends on cckb_pkg, cckb_if.
`default_nettype none

module cckb_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [23:0]             trans_key,
   input  wire logic                    q_empty,
   output logic                         q_pop,
   input  wire cckb_pkg::q_entry_type   q_data,
   cckb_rsp_if.source                   rsp
);

   logic               rsp_valid_ff, rsp_valid_in;
   cckb_pkg::addr_type addr_ff, addr_in;
   logic [31:0]        data_ff, data_in;
   logic [3:0]         mask_ff, mask_in;
   logic               last_ff, last_in;

   logic [31:0]        px_data;
   logic [3:0]         px_mask;
   logic               keyed_out;

   assign q_pop     = !q_empty && (!rsp_valid_ff || rsp.ready);
   assign keyed_out = (q_data.pixel[23:0] == trans_key);

   always_comb begin
      unique case (q_data.mode)
         cckb_pkg::MODE_OPAQUE: begin
            px_data = q_data.pixel;
            px_mask = cckb_pkg::MASK_FULL;
         end
         cckb_pkg::MODE_TINT: begin
            if (keyed_out) begin
               px_data = 32'd0;
               px_mask = cckb_pkg::MASK_NONE;
            end else begin
               px_data = {8'd0, cckb_pkg::TINT_BYTE2, 1'b0, q_data.pixel[15:9],
                          q_data.pixel[7:0]};
               px_mask = cckb_pkg::MASK_TINT;
            end
         end
         default: begin
            // keyed copy; the unused fourth mode lands here too
            px_data = keyed_out ? 32'd0 : q_data.pixel;
            px_mask = keyed_out ? cckb_pkg::MASK_NONE : cckb_pkg::MASK_FULL;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      mask_in      = mask_ff;
      last_in      = last_ff;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
         addr_in      = q_data.dest_address;
         data_in      = px_data;
         mask_in      = px_mask;
         last_in      = q_data.last;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      data_ff <= data_in;
      mask_ff <= mask_in;
      last_ff <= last_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.dest_address = addr_ff;
   assign rsp.write_data   = data_ff;
   assign rsp.byte_mask    = mask_ff;
   assign rsp.last         = last_ff;

endmodule

`default_nettype wire

>>> sv/clipped_color_key_sprite_blit.sv
// Clipped color-key sprite blitter, top level.
// Depends on cckb_pkg, cckb_if, cckb_csr, cckb_front, cckb_queue, cckb_back.
//
// Usage:
//  - Program color key and target width/height/pitch over the APB port while idle.
//  - Send a begin request (operation 0) with position, sprite size, anchor, width
//    percent and mode. The window setup then runs through its product, reciprocal
//    divide by 100 and row multiply, and window load steps, during which
//    req_chan.ready is low. An empty window leaves the block idle.
//  - Then stream the sprite's pixels (operation 1) in raster order, one per cycle
//    while req_chan.ready is high. Each pixel inside the clipped window yields one
//    response via the queue and the response register; pixels outside it, or while idle, yield none.
//  - The response marked last closes the draw; later pixels are dropped.
//  - A two-entry queue and the response register decouple the sides: while the
//    receiver stalls, up to three results are held and req_chan.ready then drops
//    until rsp_chan.ready returns. Nothing is lost or repeated.
//  - Synchronous reset returns the registers to their defaults (key 0, 640x480,
//    pitch 2560), drops any draw and empties the queue.
`default_nettype none

module clipped_color_key_sprite_blit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   cckb_req_if.sink                                req_chan,
   cckb_rsp_if.source                              rsp_chan,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [cckb_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]                        pwdata,
   output logic [31:0]                             prdata,
   output logic                                    pready
);

   cckb_pkg::cfg_type     cfg;
   cckb_pkg::q_ctrl_type  q_ctrl;
   cckb_pkg::q_entry_type q_push_data;
   cckb_pkg::q_entry_type q_pop_data;
   logic                  q_full;
   logic                  q_empty;
   logic                  q_pop;

   cckb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cckb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req    (req_chan),
      .q_ctrl (q_ctrl),
      .q_full (q_full),
      .q_data (q_push_data)
   );

   cckb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl_in   (q_ctrl),
      .full      (q_full),
      .push_data (q_push_data),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_pop_data)
   );

   cckb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .trans_key (cfg.trans_key),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (q_pop_data),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the clipped color-key sprite blitter.
// Depends on cckb_pkg, the cckb_req_if/cckb_rsp_if interfaces and clipped_color_key_sprite_blit.
// Directed table first, then constrained-by-hand random draws over several surface settings.
`default_nettype none

module testbench;

   localparam int          CYCLE_LIMIT = 200000;
   localparam int          STALL_MAX   = 8;
   localparam int          EDGE_SPAN   = 12;
   localparam int          STREAM_MAX  = 48;
   localparam int          DRAIN_WAIT  = 12;
   localparam logic [31:0] ADDR_WRAP   = (32'd1 << cckb_pkg::ADDR_BITS) - 1;
   localparam logic [1:0]  MODE_SPARE  = 2'd3;

   typedef struct {
      logic               operation;
      logic signed [12:0] start_x;
      logic signed [12:0] start_y;
      logic [6:0]         width_percent;
      logic [1:0]         draw_mode;
      logic [11:0]        sprite_cols;
      logic [11:0]        sprite_rows;
      logic [10:0]        centre_x;
      logic [10:0]        centre_y;
      logic [31:0]        pixel;
   } blit_request;

   typedef struct {
      logic [23:0] dest_address;
      logic [31:0] write_data;
      logic [3:0]  byte_mask;
      logic        last;
   } blit_write;

   typedef struct {
      blit_request rq;
      bit          typed;
      blit_write   want;
   } stim_row;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        pready;

   cckb_req_if req_chan();
   cckb_rsp_if rsp_chan();

   clipped_color_key_sprite_blit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #6 clock = ~clock;

   // surface registers as the block should hold them
   logic [23:0] key_q      = cckb_pkg::TRANS_KEY_RST;
   logic [31:0] surf_w     = cckb_pkg::TARGET_WIDTH_RST;
   logic [31:0] surf_h     = cckb_pkg::TARGET_HEIGHT_RST;
   logic [31:0] surf_pitch = cckb_pkg::TARGET_PITCH_RST;

   // draw in progress
   bit          draw_on     = 0;
   logic [1:0]  draw_mode_q = cckb_pkg::MODE_KEYED;
   logic [31:0] span_cols   = 0;
   logic [31:0] clip_col0   = 0;
   logic [31:0] clip_row0   = 0;
   logic [31:0] clip_cols   = 0;
   logic [31:0] clip_rows   = 0;
   logic [31:0] src_col     = 0;
   logic [31:0] src_row     = 0;
   logic [31:0] dest_ptr    = 0;
   logic [31:0] row_ptr     = 0;

   blit_write pending_writes[$];
   blit_write no_write;

   int  errors  = 0;
   int  checked = 0;
   int  sent    = 0;
   int  useful  = 0;
   int  cycles  = 0;
   bit  no_idle = 0;

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
   endtask

   // clip the sprite against the surface and set up the write pointers
   function automatic void open_window(input blit_request r);
      logic [31:0] cols, rows, pct;
      int          x, y, sw, lft, top, rgt, bot;
      cols = (r.sprite_cols > cckb_pkg::MAX_DIM) ? cckb_pkg::MAX_DIM : r.sprite_cols;
      rows = (r.sprite_rows > cckb_pkg::MAX_DIM) ? cckb_pkg::MAX_DIM : r.sprite_rows;
      pct  = (r.width_percent > cckb_pkg::PCT_FULL) ? cckb_pkg::PCT_FULL : r.width_percent;
      sw   = int'(cols * pct / cckb_pkg::PCT_FULL);
      x    = r.start_x;
      y    = r.start_y;
      if (r.draw_mode != cckb_pkg::MODE_OPAQUE) begin
         x = x - int'(r.centre_x);
         y = y - int'(r.centre_y);
      end
      lft = (x < 0) ? 0 : x;
      top = (y < 0) ? 0 : y;
      rgt = x + sw;
      if (rgt > int'(surf_w)) rgt = int'(surf_w);
      bot = y + int'(rows);
      if (bot > int'(surf_h)) bot = int'(surf_h);
      draw_on = 0;
      if (rgt <= lft || bot <= top) return;
      draw_on     = 1;
      draw_mode_q = r.draw_mode;
      span_cols   = cols;
      clip_col0   = lft - x;
      clip_row0   = top - y;
      clip_cols   = rgt - lft;
      clip_rows   = bot - top;
      src_col     = 0;
      src_row     = 0;
      row_ptr     = (top * surf_pitch + lft * 4) & ADDR_WRAP;
      dest_ptr    = row_ptr;
   endfunction

   // one source pixel; returns 1 when it lands in the window
   function automatic bit pixel_write(input logic [31:0] px, output blit_write w);
      logic [31:0] col, row;
      bit          hit;
      w = '{default: 0};
      if (!draw_on) return 0;
      col = src_col;
      row = src_row;
      hit = row >= clip_row0 && row - clip_row0 < clip_rows &&
            col >= clip_col0 && col - clip_col0 < clip_cols;
      src_col = col + 1;
      if (src_col >= span_cols) begin
         src_col = 0;
         src_row = row + 1;
      end
      if (!hit) return 0;
      w.dest_address = dest_ptr[23:0];
      if (draw_mode_q == cckb_pkg::MODE_OPAQUE) begin
         w.write_data = px;
         w.byte_mask  = cckb_pkg::MASK_FULL;
      end else if (px[23:0] != key_q) begin
         if (draw_mode_q == cckb_pkg::MODE_TINT) begin
            w.write_data = {8'd0, cckb_pkg::TINT_BYTE2, 1'b0, px[15:9], px[7:0]};
            w.byte_mask  = cckb_pkg::MASK_TINT;
         end else begin
            w.write_data = px;
            w.byte_mask  = cckb_pkg::MASK_FULL;
         end
      end
      if (col - clip_col0 == clip_cols - 1) begin
         w.last   = (row - clip_row0 == clip_rows - 1);
         row_ptr  = (row_ptr + surf_pitch) & ADDR_WRAP;
         dest_ptr = row_ptr;
      end else begin
         dest_ptr = (dest_ptr + 4) & ADDR_WRAP;
      end
      if (w.last) draw_on = 0;
      return 1;
   endfunction

   function automatic void apply_request(input blit_request r, input bit typed,
                                         input blit_write want);
      blit_write w;
      sent++;
      if (r.operation == cckb_pkg::OP_BEGIN) begin
         useful++;
         open_window(r);
      end else begin
         if (draw_on) useful++;
         if (pixel_write(r.pixel, w) || typed) pending_writes.push_back(typed ? want : w);
      end
   endfunction

   task automatic send_request(input blit_request r, input bit typed, input blit_write want);
      @(negedge clock);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, STALL_MAX)) @(negedge clock);
      end
      req_chan.valid         = 1'b1;
      req_chan.operation     = r.operation;
      req_chan.start_x       = r.start_x;
      req_chan.start_y       = r.start_y;
      req_chan.width_percent = r.width_percent;
      req_chan.draw_mode     = r.draw_mode;
      req_chan.sprite_cols   = r.sprite_cols;
      req_chan.sprite_rows   = r.sprite_rows;
      req_chan.centre_x      = r.centre_x;
      req_chan.centre_y      = r.centre_y;
      req_chan.pixel         = r.pixel;
      do @(posedge clock); while (!req_chan.ready);
      apply_request(r, typed, want);
   endtask

   task automatic drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic apb_cycle(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = wr;
      paddr   = {idx, 2'b00};
      pwdata  = wdata;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic csr_check(input logic [1:0] idx);
      logic [31:0] got, held;
      apb_cycle(1'b0, idx, 32'd0, got);
      case (idx)
         cckb_pkg::REG_TRANS_KEY:     held = {8'd0, key_q};
         cckb_pkg::REG_TARGET_WIDTH:  held = surf_w;
         cckb_pkg::REG_TARGET_HEIGHT: held = surf_h;
         cckb_pkg::REG_TARGET_PITCH:  held = surf_pitch;
      endcase
      if (got !== held)
         flag_error($sformatf("register %0d: expected %h, got %h", idx, held, got));
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] ignored;
      case (idx)
         cckb_pkg::REG_TRANS_KEY:     key_q = value[23:0];
         cckb_pkg::REG_TARGET_WIDTH:  surf_w = value[11:0];
         cckb_pkg::REG_TARGET_HEIGHT: surf_h = value[11:0];
         cckb_pkg::REG_TARGET_PITCH:  surf_pitch = value[13:0];
      endcase
      apb_cycle(1'b1, idx, value, ignored);
      csr_check(idx);
   endtask

   // upper bits of each write are junk the register must drop
   task automatic configure(input logic [23:0] key, input int unsigned w, h, pitch);
      drain();
      csr_write(cckb_pkg::REG_TRANS_KEY, {8'($urandom), key});
      csr_write(cckb_pkg::REG_TARGET_WIDTH, {20'($urandom), 12'(w)});
      csr_write(cckb_pkg::REG_TARGET_HEIGHT, {20'($urandom), 12'(h)});
      csr_write(cckb_pkg::REG_TARGET_PITCH, {18'($urandom), 14'(pitch)});
   endtask

   function automatic blit_request rand_request();
      blit_request r;
      r.operation     = $urandom_range(0, 1);
      r.start_x       = $urandom_range(0, 8191);
      r.start_y       = $urandom_range(0, 8191);
      r.width_percent = $urandom_range(0, 127);
      r.draw_mode     = $urandom_range(0, 3);
      r.sprite_cols   = $urandom_range(0, 4095);
      r.sprite_rows   = $urandom_range(0, 4095);
      r.centre_x      = $urandom_range(0, 2047);
      r.centre_y      = $urandom_range(0, 2047);
      r.pixel         = $urandom;
      return r;
   endfunction

   // position near an edge of the surface (or anywhere on it), anchor added back
   function automatic logic signed [12:0] near_edge(input int unsigned extent,
                                                    input int unsigned anchor);
      int v;
      case ($urandom_range(0, 2))
         0:       v = 0;
         1:       v = int'(extent);
         default: v = int'($urandom_range(0, extent));
      endcase
      v = v + int'($urandom_range(0, 2 * EDGE_SPAN)) - EDGE_SPAN + int'(anchor);
      if (v > 4095) v = 4095;
      return 13'(v);
   endfunction

   function automatic blit_request draw_begin();
      blit_request r;
      int unsigned pick;
      r = rand_request();
      r.operation = cckb_pkg::OP_BEGIN;
      pick = $urandom_range(0, 19);
      if (pick < 17) begin
         r.sprite_cols = $urandom_range(1, 12);
         r.sprite_rows = $urandom_range(1, 8);
      end else if (pick == 17) begin
         r.sprite_cols = $urandom_range(2049, 4095);
         r.sprite_rows = $urandom_range(1, 3);
      end else if (pick == 18) begin
         if ($urandom_range(0, 1)) r.sprite_cols = 0;
         else r.sprite_rows = 0;
      end
      if ($urandom_range(0, 3) != 0) begin
         r.centre_x = $urandom_range(0, 3);
         r.centre_y = $urandom_range(0, 3);
      end
      pick = $urandom_range(0, 4);
      if (pick < 3) r.width_percent = cckb_pkg::PCT_FULL;
      else if (pick == 3) r.width_percent = $urandom_range(1, 100);
      if ($urandom_range(0, 4) != 0) begin
         r.start_x = near_edge(surf_w,
                               (r.draw_mode == cckb_pkg::MODE_OPAQUE) ? 0 : r.centre_x);
         r.start_y = near_edge(surf_h,
                               (r.draw_mode == cckb_pkg::MODE_OPAQUE) ? 0 : r.centre_y);
      end
      return r;
   endfunction

   function automatic blit_request draw_pixel();
      blit_request r;
      r = rand_request();
      r.operation = cckb_pkg::OP_PIXEL;
      if ($urandom_range(0, 3) == 0) r.pixel[23:0] = key_q;
      return r;
   endfunction

   // mostly whole sprites (capped at STREAM_MAX pixels) in raster order; some cut short, overrun, or pure noise
   task automatic random_phase(input int quota);
      blit_request r;
      int          base, n, pick;
      logic [31:0] cols, rows;
      base = sent;
      while (sent - base < quota) begin
         if ($urandom_range(0, 9) == 0) begin
            send_request(rand_request(), 1'b0, no_write);
         end else begin
            r = draw_begin();
            send_request(r, 1'b0, no_write);
            cols = (r.sprite_cols > cckb_pkg::MAX_DIM) ? cckb_pkg::MAX_DIM : r.sprite_cols;
            rows = (r.sprite_rows > cckb_pkg::MAX_DIM) ? cckb_pkg::MAX_DIM : r.sprite_rows;
            n = (cols * rows > STREAM_MAX) ? STREAM_MAX : int'(cols * rows);
            pick = $urandom_range(0, 7);
            if (pick == 0) n = $urandom_range(0, n);
            else if (pick == 1) n = n + $urandom_range(1, 3);
            repeat (n) send_request(draw_pixel(), 1'b0, no_write);
         end
      end
   endtask

   function automatic stim_row row_begin(input int x, y, pct, input logic [1:0] mode,
                                         input int cols, rows, cx, cy);
      stim_row t;
      t.rq               = rand_request();
      t.rq.operation     = cckb_pkg::OP_BEGIN;
      t.rq.start_x       = 13'(x);
      t.rq.start_y       = 13'(y);
      t.rq.width_percent = 7'(pct);
      t.rq.draw_mode     = mode;
      t.rq.sprite_cols   = 12'(cols);
      t.rq.sprite_rows   = 12'(rows);
      t.rq.centre_x      = 11'(cx);
      t.rq.centre_y      = 11'(cy);
      t.typed            = 1'b0;
      t.want             = no_write;
      return t;
   endfunction

   function automatic stim_row row_pixel(input logic [31:0] px);
      stim_row t;
      t.rq           = rand_request();
      t.rq.operation = cckb_pkg::OP_PIXEL;
      t.rq.pixel     = px;
      t.typed        = 1'b0;
      t.want         = no_write;
      return t;
   endfunction

   function automatic stim_row row_write(input logic [31:0] px, input logic [23:0] addr,
                                         input logic [31:0] data, input logic [3:0] mask,
                                         input logic last);
      stim_row t;
      t = row_pixel(px);
      t.typed             = 1'b1;
      t.want.dest_address = addr;
      t.want.write_data   = data;
      t.want.byte_mask    = mask;
      t.want.last         = last;
      return t;
   endfunction

   // receiver: random stall bursts, steady ready in the final phase
   initial begin
      int hold;
      hold = 0;
      rsp_chan.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (no_idle) begin
            rsp_chan.ready = 1'b1;
         end else if (hold == 0) begin
            if (rsp_chan.ready && $urandom_range(0, 2) == 0) begin
               rsp_chan.ready = 1'b0;
               hold = $urandom_range(1, STALL_MAX);
            end else begin
               rsp_chan.ready = 1'b1;
               hold = $urandom_range(1, 2 * STALL_MAX);
            end
         end else begin
            hold--;
         end
      end
   end

   always @(posedge clock) begin
      blit_write exp_w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         checked++;
         if (pending_writes.size() == 0) begin
            flag_error($sformatf("unexpected write addr %h data %h mask %h last %b",
                                 rsp_chan.dest_address, rsp_chan.write_data,
                                 rsp_chan.byte_mask, rsp_chan.last));
         end else begin
            exp_w = pending_writes.pop_front();
            if (rsp_chan.dest_address !== exp_w.dest_address ||
                rsp_chan.write_data !== exp_w.write_data ||
                rsp_chan.byte_mask !== exp_w.byte_mask || rsp_chan.last !== exp_w.last)
               flag_error($sformatf({"write %0d: expected addr %h data %h mask %h last %b,",
                                     " got addr %h data %h mask %h last %b"}, checked,
                                    exp_w.dest_address, exp_w.write_data, exp_w.byte_mask,
                                    exp_w.last, rsp_chan.dest_address, rsp_chan.write_data,
                                    rsp_chan.byte_mask, rsp_chan.last));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("clipped_color_key_sprite_blit: mismatch");
         $finish;
      end
   end

   initial begin
      stim_row steps[$];
      reset                  = 1'b1;
      psel                   = 1'b0;
      penable                = 1'b0;
      pwrite                 = 1'b0;
      paddr                  = '0;
      pwdata                 = '0;
      req_chan.valid         = 1'b0;
      req_chan.operation     = cckb_pkg::OP_BEGIN;
      req_chan.start_x       = '0;
      req_chan.start_y       = '0;
      req_chan.width_percent = '0;
      req_chan.draw_mode     = cckb_pkg::MODE_KEYED;
      req_chan.sprite_cols   = '0;
      req_chan.sprite_rows   = '0;
      req_chan.centre_x      = '0;
      req_chan.centre_y      = '0;
      req_chan.pixel         = '0;
      no_write               = '{default: 0};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_check(cckb_pkg::REG_TRANS_KEY);
      csr_check(cckb_pkg::REG_TARGET_WIDTH);
      csr_check(cckb_pkg::REG_TARGET_HEIGHT);
      csr_check(cckb_pkg::REG_TARGET_PITCH);

      // default 640x480 surface, pitch 2560, key 0
      steps.push_back(row_pixel(32'hdead_beef));             // no draw yet: dropped
      steps.push_back(row_begin(0, 0, 100, cckb_pkg::MODE_OPAQUE, 2, 1, 5, 5));
      steps.push_back(row_write(32'h0000_0000, 24'h0, 32'h0000_0000,
                                cckb_pkg::MASK_FULL, 1'b0));
      steps.push_back(row_write(32'hffff_ffff, 24'h4, 32'hffff_ffff,
                                cckb_pkg::MASK_FULL, 1'b1));
      steps.push_back(row_pixel(32'h1234_5678));             // past the end of the window
      steps.push_back(row_begin(10, 2, 127, cckb_pkg::MODE_KEYED, 2, 2, 0, 0));
      steps.push_back(row_write(32'hab00_0000, 24'h1428, 32'h0, cckb_pkg::MASK_NONE, 1'b0));
      steps.push_back(row_write(32'h0102_0304, 24'h142c, 32'h0102_0304,
                                cckb_pkg::MASK_FULL, 1'b0));
      // restart mid-sprite: one tinted pixel in the bottom-right corner
      steps.push_back(row_begin(639, 479, 100, cckb_pkg::MODE_TINT, 3, 2, 0, 0));
      steps.push_back(row_write(32'h99aa_bbcc, 24'h12_bffc, 32'h0032_5dcc,
                                cckb_pkg::MASK_TINT, 1'b1));
      steps.push_back(row_begin(-4096, 4095, 100, MODE_SPARE, 1, 1, 0, 0));
      steps.push_back(row_begin(1, 1, 100, MODE_SPARE, 2, 3, 2, 2));
      repeat (6) steps.push_back(row_pixel($urandom));
      steps.push_back(row_begin(0, 0, 0, cckb_pkg::MODE_KEYED, 4095, 0, 0, 0));
      steps.push_back(row_pixel(32'h0000_0001));
      steps.push_back(row_begin(0, 0, 1, cckb_pkg::MODE_OPAQUE, 4095, 1, 0, 0));
      repeat (2) steps.push_back(row_pixel($urandom));
      steps.push_back(row_begin(4095, 4095, 100, cckb_pkg::MODE_KEYED, 1, 1, 2047, 2047));
      foreach (steps[i]) send_request(steps[i].rq, steps[i].typed, steps[i].want);

      configure(24'hff_ffff, 4095, 4095, 16383);             // addresses wrap
      random_phase(70);
      configure(24'h00_0000, 1, 1, 4);
      random_phase(55);
      configure(24'($urandom), 0, 300, 100);                 // nothing can be drawn
      random_phase(25);
      configure(24'($urandom), 37, 20, 0);                   // every row on one address row
      random_phase(60);
      no_idle = 1;
      configure(24'($urandom), $urandom_range(1, 2048), $urandom_range(1, 2048),
                $urandom_range(4, 8192));
      random_phase(130);
      drain();

      $display("%0d requests sent, %0d of them begins or in-draw pixels; %0d writes checked",
               sent, useful, checked);
      $display("surfaces: reset default, 4095x4095, 1x1, zero width, zero pitch, random");
      if (errors == 0) begin
         $display("clipped_color_key_sprite_blit: match");
      end else begin
         $display("clipped_color_key_sprite_blit: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
